// ===== src/bqf_pkg.sv =====
// Shared types, constants and fixed-point helpers for the biquad cascade filter.
// Depends on nothing; used by biquad_cascade_filter_core.
`timescale 1ns / 1ps
`default_nettype none

package bqf_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 20;
   localparam int SIG_W      = 40;
   localparam int CNT_W      = 4;
   localparam int FRAC_SHIFT = 16;
   localparam int HI_W       = SIG_W - FRAC_SHIFT;
   localparam int PH_W       = HI_W + COEF_W;
   localparam int PL_W       = FRAC_SHIFT + 1 + COEF_W;
   localparam int PROD_W     = PH_W;
   localparam int SUM_W      = SIG_W + 6;
   localparam int RSH_W      = PL_W + 1 - FRAC_SHIFT;
   localparam int CSR_IDX_W  = 3;
   localparam int NUM_COEF   = 5;

   localparam int MAX_SECTIONS_DEF = 8;

   // Coefficient slots.
   localparam int COEF_A0 = 0;
   localparam int COEF_A1 = 1;
   localparam int COEF_A2 = 2;
   localparam int COEF_B1 = 3;
   localparam int COEF_B2 = 4;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A0    = 3'd0,
      CSR_A1    = 3'd1,
      CSR_A2    = 3'd2,
      CSR_B1    = 3'd3,
      CSR_B2    = 3'd4,
      CSR_COUNT = 3'd5
   } csr_index_type;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_ADD  = 5'b00100,
      ST_SUM  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   typedef logic signed [SIG_W-1:0]  sig_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   // Saturate a widened sum to the 40-bit signal range.
   function automatic sig_type sat_sig(input sum_type v);
      sum_type hi;
      sum_type lo;
      hi = SUM_W'({1'b0, {(SIG_W-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         return hi[SIG_W-1:0];
      end else if (v < lo) begin
         return lo[SIG_W-1:0];
      end
      return v[SIG_W-1:0];
   endfunction

   // Combine the high and low partial products and round half up by 16 bits.
   // The high part is already a multiple of 2^16, so only the low part rounds.
   function automatic prod_type prod_round(input logic signed [PH_W-1:0] ph,
                                           input logic signed [PL_W-1:0] pl);
      logic signed [PL_W:0]    t;
      logic signed [RSH_W-1:0] sh;
      t  = {pl[PL_W-1], pl} + (PL_W+1)'(1 << (FRAC_SHIFT-1));
      sh = t[PL_W:FRAC_SHIFT];
      return ph + {{(PROD_W-RSH_W){sh[RSH_W-1]}}, sh};
   endfunction

   // Round a signal to Q1.15 and saturate to 16 bits.
   function automatic logic signed [SAMPLE_W-1:0] out_round(input sig_type y);
      logic signed [SIG_W:0]               t;
      logic signed [SIG_W-FRAC_SHIFT:0]    r;
      logic signed [SIG_W-FRAC_SHIFT:0]    hi;
      logic signed [SIG_W-FRAC_SHIFT:0]    lo;
      t  = {y[SIG_W-1], y} + (SIG_W+1)'(1 << (FRAC_SHIFT-1));
      r  = t[SIG_W:FRAC_SHIFT];
      hi = (SIG_W-FRAC_SHIFT+1)'({1'b0, {(SAMPLE_W-1){1'b1}}});
      lo = ~hi;
      if (r > hi) begin
         return hi[SAMPLE_W-1:0];
      end else if (r < lo) begin
         return lo[SAMPLE_W-1:0];
      end
      return r[SAMPLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/biquad_cascade_filter_core.sv =====
// Top level of the cascaded biquad filter: sequencer, shared multiplier bank,
// delay-state memory and configuration registers. Depends on bqf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Cascaded biquad IIR filter in transposed direct form II. Each request beat
// either filters one Q1.15 sample through the configured number of sections,
// all sharing one Q4.16 coefficient set, or (tuser high) clears every
// section's delay state and answers with zero. A filter beat runs the section
// loop, in which each section passes in turn through the shared multiplier
// bank (high and low partial products for all five coefficients), the
// rounding adders and the state update, with its two delay values read from
// and written back to the delay memory. One beat is in work at a time; a
// finished result waits in the output register without holding up the next
// request, though a later beat waits in its finish state until that register
// is free. Delay values are 40-bit Q9.31 and saturate; the output is rounded
// and saturated to 16 bits. Configuration writes are taken at any time but
// are meant to be made while the block is idle.
module biquad_cascade_filter_core #(
   parameter int MAX_SECTIONS = bqf_pkg::MAX_SECTIONS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request stream.
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [bqf_pkg::SAMPLE_W-1:0]     req_tdata,  // [15:0] sample_in
   input  wire logic                             req_tuser,  // [0] func (1 = clear)
   input  wire logic                             req_tlast,
   // Result stream.
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [bqf_pkg::SAMPLE_W-1:0]          rsp_tdata,  // [15:0] sample_out
   output logic                                  rsp_tlast,
   // Configuration write channel.
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bqf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bqf_pkg::COEF_W-1:0]       csr_wdata
);

   localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int NE_W  = bqf_pkg::CNT_W + 1;

   // Configuration registers.
   bqf_pkg::coef_type               coef_ff [bqf_pkg::NUM_COEF];
   bqf_pkg::coef_type               coef_in [bqf_pkg::NUM_COEF];
   logic [bqf_pkg::CNT_W-1:0]       cnt_ff, cnt_in;

   // Sequencer state.
   bqf_pkg::state_type              state_ff, state_in;
   logic [IDX_W-1:0]                sec_ff, sec_in;
   logic [IDX_W-1:0]                last_sec_ff, last_sec_in;
   logic [IDX_W-1:0]                wb_addr_ff, wb_addr_in;
   logic                            wb_pend_ff, wb_pend_in;
   logic                            active_ff, active_in;
   logic                            zero_ff, zero_in;
   logic                            blast_ff, blast_in;
   logic [MAX_SECTIONS-1:0]         valid_ff, valid_in;
   logic                            rd_valid_ff;

   // Datapath registers.
   bqf_pkg::sig_type                v_ff, v_in;
   logic signed [bqf_pkg::PH_W-1:0] ph_ff [bqf_pkg::NUM_COEF];
   logic signed [bqf_pkg::PH_W-1:0] ph_in [bqf_pkg::NUM_COEF];
   logic signed [bqf_pkg::PL_W-1:0] pl_ff [bqf_pkg::NUM_COEF];
   logic signed [bqf_pkg::PL_W-1:0] pl_in [bqf_pkg::NUM_COEF];
   bqf_pkg::prod_type               p_ff [bqf_pkg::NUM_COEF];
   bqf_pkg::prod_type               p_in [bqf_pkg::NUM_COEF];
   bqf_pkg::prod_type               mx1_ff, mx1_in;
   bqf_pkg::prod_type               mx2_ff, mx2_in;
   bqf_pkg::sig_type                z2_hold_ff, z2_hold_in;

   // Output register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bqf_pkg::SAMPLE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff, rsp_last_in;

   // Delay memory: one entry per section, {delay_two, delay_one}.
   logic [2*bqf_pkg::SIG_W-1:0]     delay_mem [MAX_SECTIONS];
   logic [2*bqf_pkg::SIG_W-1:0]     rd_data_ff;

   // Combinational helpers.
   logic                            req_take;
   logic                            rd_en;
   logic                            wr_en;
   logic                            rsp_load;
   logic [NE_W-1:0]                 n_eff;
   logic signed [bqf_pkg::HI_W-1:0] v_hi;
   logic signed [bqf_pkg::FRAC_SHIFT:0] v_lo;
   bqf_pkg::sig_type                x_new;
   bqf_pkg::sig_type                z1_rd, z2_rd;
   bqf_pkg::sig_type                y_new, z1_new, z2_new;

   assign req_tready = (state_ff == bqf_pkg::ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign rd_en    = (state_ff == bqf_pkg::ST_MUL);
   assign wr_en    = (state_ff == bqf_pkg::ST_SUM) && wb_pend_ff;
   assign rsp_load = (state_ff == bqf_pkg::ST_FIN) && (!rsp_valid_ff || rsp_tready);

   // Number of sections in use: zero acts as one, clamped to the memory depth.
   always_comb begin
      n_eff = (cnt_ff == '0) ? NE_W'(1) : {1'b0, cnt_ff};
      if (n_eff > NE_W'(MAX_SECTIONS)) begin
         n_eff = NE_W'(MAX_SECTIONS);
      end
   end

   // Incoming sample widened to Q9.31.
   assign x_new = {{(bqf_pkg::SIG_W-bqf_pkg::SAMPLE_W-bqf_pkg::FRAC_SHIFT){req_tdata[15]}},
                   req_tdata, {bqf_pkg::FRAC_SHIFT{1'b0}}};

   // Split the operand into a signed high part and an unsigned low part.
   assign v_hi = v_ff[bqf_pkg::SIG_W-1:bqf_pkg::FRAC_SHIFT];
   assign v_lo = {1'b0, v_ff[bqf_pkg::FRAC_SHIFT-1:0]};

   // Partial products and rounded products for all five coefficients.
   always_comb begin
      for (int i = 0; i < bqf_pkg::NUM_COEF; i++) begin
         ph_in[i] = v_hi * coef_ff[i];
         pl_in[i] = v_lo * coef_ff[i];
         p_in[i]  = bqf_pkg::prod_round(ph_ff[i], pl_ff[i]);
      end
   end

   // Section arithmetic: new output and write-back of the previous section.
   always_comb begin
      z1_rd  = rd_valid_ff ? rd_data_ff[bqf_pkg::SIG_W-1:0] : '0;
      z2_rd  = rd_valid_ff ? rd_data_ff[2*bqf_pkg::SIG_W-1:bqf_pkg::SIG_W] : '0;
      y_new  = bqf_pkg::sat_sig(bqf_pkg::SUM_W'(p_ff[bqf_pkg::COEF_A0])
                                + bqf_pkg::SUM_W'(z1_rd));
      z1_new = bqf_pkg::sat_sig(bqf_pkg::SUM_W'(mx1_ff) + bqf_pkg::SUM_W'(z2_hold_ff)
                                - bqf_pkg::SUM_W'(p_ff[bqf_pkg::COEF_B1]));
      z2_new = bqf_pkg::sat_sig(bqf_pkg::SUM_W'(mx2_ff)
                                - bqf_pkg::SUM_W'(p_ff[bqf_pkg::COEF_B2]));
   end

   // Configuration register writes.
   always_comb begin
      for (int i = 0; i < bqf_pkg::NUM_COEF; i++) begin
         coef_in[i] = coef_ff[i];
      end
      cnt_in = cnt_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bqf_pkg::CSR_A0:    coef_in[bqf_pkg::COEF_A0] = csr_wdata;
            bqf_pkg::CSR_A1:    coef_in[bqf_pkg::COEF_A1] = csr_wdata;
            bqf_pkg::CSR_A2:    coef_in[bqf_pkg::COEF_A2] = csr_wdata;
            bqf_pkg::CSR_B1:    coef_in[bqf_pkg::COEF_B1] = csr_wdata;
            bqf_pkg::CSR_B2:    coef_in[bqf_pkg::COEF_B2] = csr_wdata;
            bqf_pkg::CSR_COUNT: cnt_in = csr_wdata[bqf_pkg::CNT_W-1:0];
            default:            ;
         endcase
      end
   end

   // Sequencer: multiply, round, then update one section per pass.
   always_comb begin
      state_in    = state_ff;
      sec_in      = sec_ff;
      last_sec_in = last_sec_ff;
      wb_addr_in  = wb_addr_ff;
      wb_pend_in  = wb_pend_ff;
      active_in   = active_ff;
      zero_in     = zero_ff;
      blast_in    = blast_ff;
      valid_in    = valid_ff;
      v_in        = v_ff;
      mx1_in      = mx1_ff;
      mx2_in      = mx2_ff;
      z2_hold_in  = z2_hold_ff;

      case (state_ff)
         bqf_pkg::ST_IDLE: begin
            if (req_take) begin
               blast_in    = req_tlast;
               zero_in     = req_tuser;
               sec_in      = '0;
               last_sec_in = IDX_W'(n_eff - NE_W'(1));
               wb_pend_in  = 1'b0;
               active_in   = 1'b1;
               v_in        = x_new;
               if (req_tuser) begin
                  valid_in = '0;
                  state_in = bqf_pkg::ST_FIN;
               end else begin
                  state_in = bqf_pkg::ST_MUL;
               end
            end
         end
         bqf_pkg::ST_MUL: begin
            state_in = bqf_pkg::ST_ADD;
         end
         bqf_pkg::ST_ADD: begin
            state_in = bqf_pkg::ST_SUM;
         end
         bqf_pkg::ST_SUM: begin
            if (wr_en) begin
               valid_in[wb_addr_ff] = 1'b1;
            end
            if (active_ff) begin
               v_in       = y_new;
               mx1_in     = p_ff[bqf_pkg::COEF_A1];
               mx2_in     = p_ff[bqf_pkg::COEF_A2];
               z2_hold_in = z2_rd;
               wb_pend_in = 1'b1;
               wb_addr_in = sec_ff;
               if (sec_ff == last_sec_ff) begin
                  active_in = 1'b0;
               end else begin
                  sec_in = sec_ff + IDX_W'(1);
               end
               state_in = bqf_pkg::ST_MUL;
            end else begin
               wb_pend_in = 1'b0;
               state_in   = bqf_pkg::ST_FIN;
            end
         end
         bqf_pkg::ST_FIN: begin
            if (rsp_load) begin
               state_in = bqf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bqf_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register: loads a finished result, holds it until taken.
   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_data_in = zero_ff ? '0 : bqf_pkg::out_round(v_ff);
         rsp_last_in = blast_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bqf_pkg::ST_IDLE;
         sec_ff      <= '0;
         last_sec_ff <= '0;
         wb_pend_ff  <= 1'b0;
         active_ff   <= 1'b0;
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff      <= bqf_pkg::CNT_W'(1);
         coef_ff[bqf_pkg::COEF_A0] <= bqf_pkg::COEF_W'(1 << bqf_pkg::FRAC_SHIFT);
         coef_ff[bqf_pkg::COEF_A1] <= '0;
         coef_ff[bqf_pkg::COEF_A2] <= '0;
         coef_ff[bqf_pkg::COEF_B1] <= '0;
         coef_ff[bqf_pkg::COEF_B2] <= '0;
      end else begin
         state_ff    <= state_in;
         sec_ff      <= sec_in;
         last_sec_ff <= last_sec_in;
         wb_pend_ff  <= wb_pend_in;
         active_ff   <= active_in;
         valid_ff    <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[sec_ff];
         end
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff      <= cnt_in;
         for (int i = 0; i < bqf_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= coef_in[i];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      wb_addr_ff  <= wb_addr_in;
      zero_ff     <= zero_in;
      blast_ff    <= blast_in;
      v_ff        <= v_in;
      mx1_ff      <= mx1_in;
      mx2_ff      <= mx2_in;
      z2_hold_ff  <= z2_hold_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      for (int i = 0; i < bqf_pkg::NUM_COEF; i++) begin
         ph_ff[i] <= ph_in[i];
         pl_ff[i] <= pl_in[i];
         p_ff[i]  <= p_in[i];
      end
   end

   // Delay memory: one synchronous read and one write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         delay_mem[wb_addr_ff] <= {z2_new, z1_new};
      end
      if (rd_en) begin
         rd_data_ff <= delay_mem[sec_ff];
      end
   end

   // Read and write never meet on one entry in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wb_addr_ff != sec_ff))
      else $error("delay memory read and write collide");

   // A clear beat invalidates every section's delay state at once.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tuser) |=> (valid_ff == '0))
      else $error("clear did not invalidate delay state");

   // The section counter stays within the sections in use.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != bqf_pkg::ST_IDLE) |-> (sec_ff <= last_sec_ff))
      else $error("section index beyond sections in use");

   // A write-back is only pending for a section already processed.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wb_addr_ff <= sec_ff))
      else $error("write-back to a section not yet processed");

   // A result only appears once the sequencer has finished the beat.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bqf_pkg::ST_FIN))
      else $error("result loaded outside the finish state");

endmodule

`default_nettype wire
